FILE: rtl/core/ffpa_pkg.sv
// shared constants, types and helpers of the first-fit partition allocator
package ffpa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int MAX_FAILED = 16;
  localparam int SIZE_BITS  = 16;

  // fixed widths of the external fields
  localparam int IO_IDX_W  = 4;
  localparam int IO_SIZE_W = 16;
  localparam int TOTAL_W   = 20;
  localparam int CFG_W     = 5;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // derived widths
  localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LIDX_W  = (IDX_W > IO_IDX_W) ? IDX_W : IO_IDX_W;
  localparam int LIM_W   = $clog2(NUM_BLOCKS + 1);
  localparam int FIDX_W  = (MAX_FAILED > 1) ? $clog2(MAX_FAILED) : 1;
  localparam int FCNT_W  = $clog2(MAX_FAILED + 1);
  localparam int SUM_W   = ((TOTAL_W > SIZE_BITS) ? TOTAL_W : SIZE_BITS) + 1;
  localparam int FCMP_W  = (TOTAL_W > SIZE_BITS) ? TOTAL_W : SIZE_BITS;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ALLOC  = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLK,
    ST_FAIL,
    ST_FIN
  } state_t;

  // token walking the block cells
  typedef struct packed {
    logic                 valid;
    req_t                 op;
    logic [SIZE_BITS-1:0] req_size;
    logic                 found;
    logic [LIDX_W-1:0]    idx;
    logic [SIZE_BITS-1:0] left;
    logic [TOTAL_W-1:0]   ftotal;
  } blk_tok_t;

  // broadcast control to the block cells
  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic [LIDX_W-1:0]    idx;
    logic [SIZE_BITS-1:0] size;
  } blk_ctl_t;

  // token walking the failed-list cells
  typedef struct packed {
    logic                 valid;
    logic [TOTAL_W-1:0]   ftotal;
    logic [SIZE_BITS-1:0] efrag;
  } fail_tok_t;

  // write port of the failed-list cells
  typedef struct packed {
    logic                 wr;
    logic [FIDX_W-1:0]    idx;
    logic [SIZE_BITS-1:0] size;
  } fail_ctl_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [SIZE_BITS-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/ffpa_if.sv
// request and result channel interfaces of the partition allocator
interface ffpa_req_if;
  import ffpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [IO_IDX_W-1:0]  block_index;
  logic [IO_SIZE_W-1:0] size;

  modport source (output valid, req_type, block_index, size, input ready);
  modport sink   (input valid, req_type, block_index, size, output ready);
endinterface

interface ffpa_res_if;
  import ffpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [IO_IDX_W-1:0]  granted_block;
  logic [IO_SIZE_W-1:0] leftover;
  logic [TOTAL_W-1:0]   internal_total;
  logic [TOTAL_W-1:0]   free_total;
  logic [IO_SIZE_W-1:0] external_frag;
  logic                 list_full;

  modport source (output valid, granted, granted_block, leftover, internal_total,
                  free_total, external_frag, list_full, input ready);
  modport sink   (input valid, granted, granted_block, leftover, internal_total,
                  free_total, external_frag, list_full, output ready);
endinterface

FILE: rtl/core/ffpa_blk_cell.sv
// one partition block cell: holds a size and a used flag, serves the passing token
module ffpa_blk_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ffpa_pkg::IDX_W-1:0]   cell_idx,
  input  logic [ffpa_pkg::LIM_W-1:0]   lim,
  input  ffpa_pkg::blk_ctl_t           ctl,
  input  ffpa_pkg::blk_tok_t           tok_in,
  output ffpa_pkg::blk_tok_t           tok_out
);
  import ffpa_pkg::*;

  logic [SIZE_BITS-1:0] size_q;
  logic                 used;
  logic                 load_hit;
  logic                 free_here;
  logic                 grant;
  blk_tok_t             tok_next;

  assign load_hit  = ctl.load && (ctl.idx == LIDX_W'(cell_idx));
  assign free_here = !used && (LIM_W'(cell_idx) < lim);
  assign grant     = tok_in.valid && (tok_in.op == REQ_ALLOC) && !tok_in.found &&
                     free_here && (size_q >= tok_in.req_size);

  always_comb begin
    tok_next = tok_in;
    if (grant) begin
      tok_next.found = 1'b1;
      tok_next.idx   = LIDX_W'(cell_idx);
      tok_next.left  = size_q - tok_in.req_size;
    end
    if (tok_in.valid && (tok_in.op == REQ_REPORT) && free_here) begin
      tok_next.ftotal = sat_add(tok_in.ftotal, size_q);
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      size_q <= ctl.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.clear || load_hit) begin
      used <= 1'b0;
    end else if (grant) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: rtl/core/ffpa_fail_cell.sv
// one failed-list cell: holds a recorded size, passes on the largest live size that fits the token's free total
module ffpa_fail_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ffpa_pkg::FIDX_W-1:0]   cell_idx,
  input  logic [ffpa_pkg::FCNT_W-1:0]   count,
  input  ffpa_pkg::fail_ctl_t           ctl,
  input  ffpa_pkg::fail_tok_t           tok_in,
  output ffpa_pkg::fail_tok_t           tok_out
);
  import ffpa_pkg::*;

  logic [SIZE_BITS-1:0] entry;
  logic                 live;
  logic                 better;
  fail_tok_t            tok_next;

  assign live   = FCNT_W'(cell_idx) < count;
  assign better = live && (FCMP_W'(entry) <= FCMP_W'(tok_in.ftotal)) &&
                  (entry > tok_in.efrag);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && better) begin
      tok_next.efrag = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && (ctl.idx == cell_idx)) begin
      entry <= ctl.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: rtl/core/first_fit_partition_allocator_top.sv
// top level of the first-fit fixed-partition allocator
//
// usage
// - req channel: one transfer per request (load, allocate, report, clear run);
//   ready is high only while the block is idle, so one request is in work at a time
// - res channel: exactly one result transfer per request, in request order,
//   held in an output register until the receiver takes it
// - cfg_we / cfg_wdata: writes block_count; write only while the block is idle
// - load and clear go straight to the final step; allocate and report first send a
//   token that steps one cell per cycle through the row of block cells, and for a
//   report also through the row of failed-list cells, before the final step
// - a stalled receiver holds the result; the block then waits in its final step
//   and takes no new request until the result register is free
// - reset clears all used flags, the leftover sum, the failed count and the
//   overflow flag, and sets block_count to 16; block sizes stay unknown until
//   loaded
module first_fit_partition_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0]  cfg_wdata,
  ffpa_req_if.sink                    req,
  ffpa_res_if.source                  res
);
  import ffpa_pkg::*;

  // fsm
  state_t state;
  state_t state_next;

  // configuration and run state
  logic [CFG_W-1:0]   block_count;
  logic [LIM_W-1:0]   lim;
  logic [TOTAL_W-1:0] leftover_sum;
  logic [FCNT_W-1:0]  failed_count;
  logic               overflow_seen;

  // cell chains
  blk_tok_t  blk_link  [NUM_BLOCKS+1];
  fail_tok_t fail_link [MAX_FAILED+1];
  blk_tok_t  blk_in;
  fail_tok_t fail_in;
  blk_ctl_t  blk_ctl;
  fail_ctl_t fail_ctl;

  // finished request waiting for the result register
  blk_tok_t             fin;
  logic [SIZE_BITS-1:0] fin_efrag;

  logic req_xfer;
  logic res_free;
  logic commit;
  logic fail_rec;

  // result register values after this request's update
  logic [TOTAL_W-1:0] sum_next;
  logic               overflow_next;

  assign req.ready = (state == ST_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign res_free  = !res.valid || res.ready;
  assign commit    = (state == ST_FIN) && res_free;

  // a block_count above the table size acts as the table size
  assign lim = (int'(block_count) > NUM_BLOCKS) ? LIM_W'(NUM_BLOCKS) : LIM_W'(block_count);

  // failed allocate: record while there is room, otherwise flag the overflow
  assign fail_rec = commit && (fin.op == REQ_ALLOC) && !fin.found;

  // all table changes for load and clear happen when the result is committed
  always_comb begin
    blk_ctl.load   = commit && (fin.op == REQ_LOAD);
    blk_ctl.clear  = commit && (fin.op == REQ_CLEAR);
    blk_ctl.idx    = fin.idx;
    blk_ctl.size   = fin.req_size;
    fail_ctl.wr    = fail_rec && (failed_count < FCNT_W'(MAX_FAILED));
    fail_ctl.idx   = FIDX_W'(failed_count);
    fail_ctl.size  = fin.req_size;
  end

  always_comb begin
    sum_next      = leftover_sum;
    overflow_next = overflow_seen;
    unique case (fin.op)
      REQ_ALLOC: begin
        if (fin.found) begin
          sum_next = sat_add(leftover_sum, fin.left);
        end else if (failed_count >= FCNT_W'(MAX_FAILED)) begin
          overflow_next = 1'b1;
        end
      end
      REQ_CLEAR: begin
        sum_next      = '0;
        overflow_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // row of block cells
  assign blk_link[0] = blk_in;
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_blk
    ffpa_blk_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_idx(IDX_W'(i)),
      .lim     (lim),
      .ctl     (blk_ctl),
      .tok_in  (blk_link[i]),
      .tok_out (blk_link[i+1])
    );
  end

  // row of failed-list cells
  assign fail_link[0] = fail_in;
  for (genvar i = 0; i < MAX_FAILED; i++) begin : g_fail
    ffpa_fail_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_idx(FIDX_W'(i)),
      .count   (failed_count),
      .ctl     (fail_ctl),
      .tok_in  (fail_link[i]),
      .tok_out (fail_link[i+1])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          if ((req_t'(req.req_type) == REQ_ALLOC) || (req_t'(req.req_type) == REQ_REPORT)) begin
            state_next = ST_BLK;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_BLK: begin
        if (blk_link[NUM_BLOCKS].valid) begin
          state_next = (blk_link[NUM_BLOCKS].op == REQ_REPORT) ? ST_FAIL : ST_FIN;
        end
      end
      ST_FAIL: begin
        if (fail_link[MAX_FAILED].valid) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // token launch into the block row, single cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_in.valid <= 1'b0;
    end else begin
      blk_in.valid    <= req_xfer && ((req_t'(req.req_type) == REQ_ALLOC) ||
                                      (req_t'(req.req_type) == REQ_REPORT));
      blk_in.op       <= req_t'(req.req_type);
      blk_in.req_size <= SIZE_BITS'(req.size);
      blk_in.found    <= 1'b0;
      blk_in.idx      <= '0;
      blk_in.left     <= '0;
      blk_in.ftotal   <= '0;
    end
  end

  // token launch into the failed-list row once the free sum is known
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_in.valid <= 1'b0;
    end else begin
      fail_in.valid  <= (state == ST_BLK) && blk_link[NUM_BLOCKS].valid &&
                        (blk_link[NUM_BLOCKS].op == REQ_REPORT);
      fail_in.ftotal <= blk_link[NUM_BLOCKS].ftotal;
      fail_in.efrag  <= '0;
    end
  end

  // capture of the finished request
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      fin.valid    <= 1'b1;
      fin.op       <= req_t'(req.req_type);
      fin.req_size <= SIZE_BITS'(req.size);
      fin.found    <= 1'b0;
      fin.idx      <= LIDX_W'(req.block_index);
      fin.left     <= '0;
      fin.ftotal   <= '0;
      fin_efrag    <= '0;
    end else if ((state == ST_BLK) && blk_link[NUM_BLOCKS].valid) begin
      fin       <= blk_link[NUM_BLOCKS];
      fin_efrag <= '0;
    end else if ((state == ST_FAIL) && fail_link[MAX_FAILED].valid) begin
      fin_efrag <= fail_link[MAX_FAILED].efrag;
    end
  end

  // configuration and run totals
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= CFG_W'(16);
      leftover_sum  <= '0;
      failed_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      if (commit) begin
        leftover_sum  <= sum_next;
        overflow_seen <= overflow_next;
        if (fin.op == REQ_CLEAR) begin
          failed_count <= '0;
        end else if (fail_ctl.wr) begin
          failed_count <= failed_count + FCNT_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (commit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.granted        <= (fin.op == REQ_ALLOC) && fin.found;
      res.granted_block  <= ((fin.op == REQ_ALLOC) && fin.found) ? IO_IDX_W'(fin.idx) : '0;
      res.leftover       <= ((fin.op == REQ_ALLOC) && fin.found) ? IO_SIZE_W'(fin.left) : '0;
      res.internal_total <= sum_next;
      res.free_total     <= (fin.op == REQ_REPORT) ? fin.ftotal : '0;
      res.external_frag  <= (fin.op == REQ_REPORT) ? IO_SIZE_W'(fin_efrag) : '0;
      res.list_full      <= overflow_next;
    end
  end

endmodule

FILE: tb/first_fit_partition_allocator_top_tb.sv
// self-checking testbench of the first-fit partition allocator: directed table then random phases
`timescale 1ns / 1ps

module first_fit_partition_allocator_top_tb;
  import ffpa_pkg::*;

  // generous upper bound on the whole run, in ns
  localparam int RUN_LIMIT_NS = 5_000_000;
  // bound on the slowest request and its result, used for the final settle
  localparam int SLOWEST_REQ  = NUM_BLOCKS + MAX_FAILED + 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 73;
  localparam int LONG_HOLD    = 300;

  // one result as the allocator gives it
  typedef struct packed {
    logic                 granted;
    logic [IO_IDX_W-1:0]  granted_block;
    logic [IO_SIZE_W-1:0] leftover;
    logic [TOTAL_W-1:0]   internal_total;
    logic [TOTAL_W-1:0]   free_total;
    logic [IO_SIZE_W-1:0] external_frag;
    logic                 list_full;
  } alloc_outcome_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    req_t                 op;
    logic [IO_IDX_W-1:0]  idx;
    logic [IO_SIZE_W-1:0] size;
    logic                 typed;
    alloc_outcome_t       want;
  } dir_row_t;

  localparam alloc_outcome_t NO_OUTCOME = '0;
  // zero-size request on a fresh 100-entry block: whole block left over
  localparam alloc_outcome_t ZERO_SIZE_GRANT = '{1'b1, 4'd0, 16'd100, 20'd100, 20'd0, 16'd0,
                                                 1'b0};

  // directed part, run with four active blocks
  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{REQ_LOAD,   4'd0,  16'd100,    1'b1, NO_OUTCOME},      // loads answer with all zero
    '{REQ_LOAD,   4'd1,  16'hFFFF,   1'b1, NO_OUTCOME},      // largest block size
    '{REQ_LOAD,   4'd2,  16'd0,      1'b1, NO_OUTCOME},      // empty block
    '{REQ_LOAD,   4'd3,  16'd300,    1'b1, NO_OUTCOME},
    '{REQ_LOAD,   4'd15, 16'd7,      1'b1, NO_OUTCOME},      // top index, outside active range
    '{REQ_ALLOC,  4'd0,  16'd0,      1'b1, ZERO_SIZE_GRANT}, // zero-size request
    '{REQ_ALLOC,  4'd0,  16'd200,    1'b0, NO_OUTCOME},      // skips used block 0
    '{REQ_ALLOC,  4'd0,  16'hFFFF,   1'b0, NO_OUTCOME},      // largest request, refused
    '{REQ_REPORT, 4'd0,  16'd0,      1'b0, NO_OUTCOME},
    '{REQ_ALLOC,  4'd0,  16'd250,    1'b0, NO_OUTCOME},
    '{REQ_ALLOC,  4'd0,  16'd0,      1'b0, NO_OUTCOME},      // exact fit on the empty block
    '{REQ_ALLOC,  4'd0,  16'd1,      1'b0, NO_OUTCOME},      // nothing free left
    '{REQ_LOAD,   4'd1,  16'd500,    1'b0, NO_OUTCOME},      // reload of a used block frees it
    '{REQ_REPORT, 4'd0,  16'd0,      1'b0, NO_OUTCOME},      // small refusal now fits the sum
    '{REQ_ALLOC,  4'd0,  16'd400,    1'b0, NO_OUTCOME},
    '{REQ_ALLOC,  4'd0,  16'h5555,   1'b0, NO_OUTCOME},
    '{REQ_ALLOC,  4'd0,  16'hAAAA,   1'b0, NO_OUTCOME},
    '{REQ_REPORT, 4'd0,  16'd0,      1'b0, NO_OUTCOME},
    '{REQ_CLEAR,  4'd0,  16'd0,      1'b1, NO_OUTCOME},      // clear run zeroes every total
    '{REQ_REPORT, 4'd0,  16'd0,      1'b0, NO_OUTCOME},      // every block free again
    '{REQ_ALLOC,  4'd0,  16'hFFFF,   1'b0, NO_OUTCOME}
  };

  // block count and clear-run share of each random phase; 0 and 31 are the extremes,
  // 17 and 31 exercise the count above the table size
  localparam logic [CFG_W-1:0] PHASE_COUNT [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17,
                                                       5'd9, 5'd16, 5'd8};
  localparam int PHASE_CLEAR_PCT [PHASES] = '{3, 3, 0, 4, 6, 0, 2, 10};

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  ffpa_req_if req_bus ();
  ffpa_res_if res_bus ();

  first_fit_partition_allocator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .res       (res_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted allocator state
  logic [CFG_W-1:0]     part_count;
  logic [SIZE_BITS-1:0] part_size   [NUM_BLOCKS];
  logic                 part_used   [NUM_BLOCKS];
  logic                 part_loaded [NUM_BLOCKS];
  logic [TOTAL_W-1:0]   leftover_acc;
  logic [SIZE_BITS-1:0] refused_size [MAX_FAILED];
  int                   refused_fill;
  logic                 refusals_lost;

  // results still owed by the allocator, oldest first
  alloc_outcome_t awaited_outcomes [$];

  int  errors;
  bit  steady;           // both sides stop idling
  bit  hold_results_req; // asks the receiver for one long hold-off

  // what the run reached, for the summary
  int n_loads, n_grants, n_refusals, n_reports, n_clears, n_frag_hits;
  int n_saturated, n_list_overflows;

  function automatic logic [TOTAL_W-1:0] add_capped(input logic [TOTAL_W-1:0] a,
                                                    input logic [SIZE_BITS-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + b;
    return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  // works out one result and moves the predicted state on
  function automatic alloc_outcome_t first_fit_outcome(input req_t op,
                                                       input logic [IO_IDX_W-1:0] idx,
                                                       input logic [IO_SIZE_W-1:0] sz);
    alloc_outcome_t o;
    int             n;
    int             j;
    o = '0;
    n = (part_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(part_count);
    case (op)
      REQ_LOAD: begin
        part_size[idx]   = sz;
        part_used[idx]   = 1'b0;
        part_loaded[idx] = 1'b1;
        n_loads++;
      end
      REQ_ALLOC: begin
        for (j = 0; j < n && !o.granted; j++) begin
          if (!part_used[j] && part_size[j] >= sz) begin
            part_used[j]    = 1'b1;
            o.granted       = 1'b1;
            o.granted_block = IO_IDX_W'(j);
            o.leftover      = part_size[j] - sz;
            leftover_acc    = add_capped(leftover_acc, o.leftover);
          end
        end
        if (o.granted) begin
          n_grants++;
          if (leftover_acc == TOTAL_MAX) n_saturated++;
        end else begin
          n_refusals++;
          if (refused_fill < MAX_FAILED) begin
            refused_size[refused_fill] = sz;
            refused_fill++;
          end else begin
            if (!refusals_lost) n_list_overflows++;
            refusals_lost = 1'b1;
          end
        end
      end
      REQ_REPORT: begin
        for (j = 0; j < n; j++)
          if (!part_used[j]) o.free_total = add_capped(o.free_total, part_size[j]);
        for (j = 0; j < refused_fill; j++)
          if (TOTAL_W'(refused_size[j]) <= o.free_total && refused_size[j] > o.external_frag)
            o.external_frag = refused_size[j];
        n_reports++;
        if (o.external_frag != 0) n_frag_hits++;
      end
      default: begin
        for (j = 0; j < NUM_BLOCKS; j++) part_used[j] = 1'b0;
        leftover_acc  = '0;
        refused_fill  = 0;
        refusals_lost = 1'b0;
        n_clears++;
      end
    endcase
    o.internal_total = leftover_acc;
    o.list_full      = refusals_lost;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                      input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // offers one request and waits for its transfer; valid stays high afterwards
  task automatic offer_request(input req_t op, input logic [IO_IDX_W-1:0] idx,
                               input logic [IO_SIZE_W-1:0] sz, input logic typed,
                               input alloc_outcome_t want);
    alloc_outcome_t predicted;
    while (!steady && $urandom_range(99) < 35) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid       = 1'b1;
    req_bus.req_type    = op;
    req_bus.block_index = idx;
    req_bus.size        = sz;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    // the predictor always runs so that its state keeps up with typed rows
    predicted = first_fit_outcome(op, idx, sz);
    awaited_outcomes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // sender goes quiet until every owed result has been taken
  task automatic wait_for_results();
    req_bus.valid = 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // every request answers, so an empty queue means the allocator is idle
  task automatic set_block_count(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    part_count = value;
  endtask

  function automatic logic [IO_SIZE_W-1:0] pick_block_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return IO_SIZE_W'($urandom_range(255));
      4, 5, 6: return IO_SIZE_W'($urandom_range(65535, 60000));
      default: return IO_SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [IO_SIZE_W-1:0] pick_request_size();
    logic [IO_SIZE_W-1:0] base;
    base = part_size[$urandom_range(NUM_BLOCKS - 1)];
    case ($urandom_range(19))
      0:                      return '0;
      1:                      return '1;
      2, 3, 4, 5, 6, 7, 8:    return IO_SIZE_W'($urandom_range(2047));
      9, 10, 11, 12:          return IO_SIZE_W'($urandom);
      // around an existing block size, to hit exact and near fits
      default:                return base + IO_SIZE_W'($urandom_range(2)) - 1'b1;
    endcase
  endfunction

  // one random request; a search or a sum over a never-loaded block is turned into its load
  task automatic offer_random_request(input int clear_pct);
    req_t                 op;
    logic [IO_IDX_W-1:0]  idx;
    logic [IO_SIZE_W-1:0] sz;
    int                   roll;
    int                   n;
    int                   j;
    roll = $urandom_range(99);
    idx  = IO_IDX_W'($urandom_range(NUM_BLOCKS - 1));
    sz   = '0;
    if (roll < clear_pct)           op = REQ_CLEAR;
    else if (roll < clear_pct + 28) op = REQ_LOAD;
    else if (roll < clear_pct + 44) op = REQ_REPORT;
    else                            op = REQ_ALLOC;
    if (op == REQ_ALLOC || op == REQ_REPORT) begin
      n = (part_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(part_count);
      for (j = n - 1; j >= 0; j--) begin
        if (!part_loaded[j]) begin
          op  = REQ_LOAD;
          idx = IO_IDX_W'(j);
        end
      end
    end
    case (op)
      REQ_LOAD:  sz = pick_block_size();
      REQ_ALLOC: sz = pick_request_size();
      default:   sz = IO_SIZE_W'($urandom); // ignored by report and clear run
    endcase
    offer_request(op, idx, sz, 1'b0, NO_OUTCOME);
  endtask

  // receiving side: random stalls, one long hold-off on request, checks at the rising edge
  initial begin
    alloc_outcome_t want;
    int             hold_left;
    res_bus.ready = 1'b0;
    hold_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_results_req) begin
        hold_results_req = 1'b0;
        hold_left        = LONG_HOLD;
      end
      if (rst) begin
        res_bus.ready = 1'b0;
      end else if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = steady || ($urandom_range(99) >= 35);
      end
      @(posedge clk);
      if (res_bus.valid === 1'b1 && res_bus.ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("granted",        want.granted,        res_bus.granted);
          check_field("granted_block",  want.granted_block,  res_bus.granted_block);
          check_field("leftover",       want.leftover,       res_bus.leftover);
          check_field("internal_total", want.internal_total, res_bus.internal_total);
          check_field("free_total",     want.free_total,     res_bus.free_total);
          check_field("external_frag",  want.external_frag,  res_bus.external_frag);
          check_field("list_full",      want.list_full,      res_bus.list_full);
        end
      end
    end
  end

  // sending side and run control
  initial begin
    int p;
    int k;
    // every input known from time zero
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_LOAD;
    req_bus.block_index = '0;
    req_bus.size        = '0;
    steady              = 1'b0;
    hold_results_req    = 1'b0;
    errors              = 0;

    // predicted reset state; sizes read as zero but are never searched before a load
    part_count    = 5'd16;
    leftover_acc  = '0;
    refused_fill  = 0;
    refusals_lost = 1'b0;
    for (k = 0; k < NUM_BLOCKS; k++) begin
      part_size[k]   = '0;
      part_used[k]   = 1'b0;
      part_loaded[k] = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table on four active blocks
    set_block_count(5'd4);
    foreach (DIRECTED[i])
      offer_request(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].size, DIRECTED[i].typed,
                    DIRECTED[i].want);

    // random phases, each under its own block count, written while idle
    for (p = 0; p < PHASES; p++) begin
      set_block_count(PHASE_COUNT[p]);
      steady = (p == 3); // a stretch where neither side idles
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // long receiver hold-off while requests keep coming, so the input stalls
        if (p == 2 && k == 30) hold_results_req = 1'b1;
        // sender pause until the allocator has answered everything
        if (p == 5 && k == 40) wait_for_results();
        offer_random_request(PHASE_CLEAR_PCT[p]);
      end
    end
    steady = 1'b0;

    // drain, then give any stray result time to show up
    wait_for_results();
    repeat (3 * SLOWEST_REQ) @(posedge clk);
    if (awaited_outcomes.size() != 0) begin
      $error("%0d results never arrived", awaited_outcomes.size());
      errors++;
    end

    $display("loads %0d, grants %0d, refusals %0d, reports %0d (%0d fragmented), clears %0d",
             n_loads, n_grants, n_refusals, n_reports, n_frag_hits, n_clears);
    $display("block counts 0 to 31; sum capped %0d times, list overflowed %0d times",
             n_saturated, n_list_overflows);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $error("run did not finish in time");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_if.sv
rtl/core/ffpa_blk_cell.sv
rtl/core/ffpa_fail_cell.sv
rtl/core/first_fit_partition_allocator_top.sv
tb/first_fit_partition_allocator_top_tb.sv
